// ===== design/plmc_pkg.sv =====
package plmc_pkg;

  // list geometry
  localparam int DEPTH = 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 31;

  // command codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_NEXT   = 2'd1,
    OP_PREV   = 2'd2,
    OP_SWITCH = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_NEXT   = 3'd1,
    ST_NO_PREV   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REWIND,
    S_SCAN,
    S_RESTORE,
    S_RESULT
  } state_t;

  // controls broadcast from the sequencer to the ring of cells
  typedef struct packed {
    logic             rot_next;
    logic             rot_prev;
    logic             wr_en;
    logic [IDX_W-1:0] wr_off;
    logic [ID_W-1:0]  wr_data;
  } ring_ctrl_t;

endpackage

// ===== design/plmc_if.sv =====
// command channel
interface plmc_cmd_if
  import plmc_pkg::*;
();
  logic            valid;
  logic            ready;
  opcode_t         opcode;
  logic [ID_W-1:0] song_id;

  modport source (output valid, output opcode, output song_id, input ready);
  modport sink   (input valid, input opcode, input song_id, output ready);
endinterface

// result channel
interface plmc_res_if
  import plmc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] current_id;
  logic            current_valid;
  status_t         status;

  modport source (output valid, output current_id, output current_valid, output status,
                  input ready);
  modport sink   (input valid, input current_id, input current_valid, input status,
                  output ready);
endinterface

// ===== design/plmc_cell.sv =====
module plmc_cell
  import plmc_pkg::*;
(
  input  logic            clk,
  input  ring_ctrl_t      ctrl,
  input  logic            we,
  input  logic [ID_W-1:0] from_left,
  input  logic [ID_W-1:0] from_right,
  output logic [ID_W-1:0] entry
);

  // one ring slot: local write, or take a neighbor's value when the ring turns
  always_ff @(posedge clk) begin
    if (we) begin
      entry <= ctrl.wr_data;
    end else if (ctrl.rot_next) begin
      entry <= from_right;
    end else if (ctrl.rot_prev) begin
      entry <= from_left;
    end
  end

endmodule

// ===== design/plmc_ctrl.sv =====
module plmc_ctrl
  import plmc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  opcode_t         cmd_opcode,
  input  logic [ID_W-1:0] cmd_song_id,
  input  logic [ID_W-1:0] head,
  output ring_ctrl_t      ctrl,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [ID_W-1:0] res_id,
  output logic            res_id_valid,
  output status_t         res_status
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [IDX_W-1:0] saved, saved_next;
  logic [ID_W-1:0]  query, query_next;
  status_t          st, st_next;
  logic             res_valid_next;
  logic [ID_W-1:0]  res_id_next;
  logic             res_id_valid_next;
  status_t          res_status_next;
  logic [CNT_W-1:0] pos_plus;
  logic [CNT_W-1:0] tail_off;

  assign pos_plus = CNT_W'(pos) + CNT_W'(1);
  assign tail_off = count - CNT_W'(pos);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pos       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pos       <= pos_next;
      res_valid <= res_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    saved        <= saved_next;
    query        <= query_next;
    st           <= st_next;
    res_id       <= res_id_next;
    res_id_valid <= res_id_valid_next;
    res_status   <= res_status_next;
  end

  // sequencer: pos is the list index of the entry sitting in cell zero
  always_comb begin
    state_next        = state;
    count_next        = count;
    pos_next          = pos;
    saved_next        = saved;
    query_next        = query;
    st_next           = st;
    res_valid_next    = res_valid && !res_ready;
    res_id_next       = res_id;
    res_id_valid_next = res_id_valid;
    res_status_next   = res_status;
    cmd_ready         = 1'b0;
    ctrl.rot_next     = 1'b0;
    ctrl.rot_prev     = 1'b0;
    ctrl.wr_en        = 1'b0;
    ctrl.wr_off       = tail_off[IDX_W-1:0];
    ctrl.wr_data      = cmd_song_id;

    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          st_next    = ST_OK;
          state_next = S_RESULT;
          unique case (cmd_opcode)
            OP_APPEND: begin
              if (count == CNT_W'(DEPTH)) begin
                st_next = ST_FULL;
              end else begin
                ctrl.wr_en = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            OP_NEXT: begin
              if (count != '0 && pos_plus < count) begin
                ctrl.rot_next = 1'b1;
                pos_next      = pos + IDX_W'(1);
              end else begin
                st_next = ST_NO_NEXT;
              end
            end
            OP_PREV: begin
              if (count != '0 && pos != '0) begin
                ctrl.rot_prev = 1'b1;
                pos_next      = pos - IDX_W'(1);
              end else begin
                st_next = ST_NO_PREV;
              end
            end
            OP_SWITCH: begin
              query_next = cmd_song_id;
              saved_next = pos;
              if (count == '0) begin
                st_next = ST_NOT_FOUND;
              end else begin
                state_next = S_REWIND;
              end
            end
            default: begin
              st_next = ST_NOT_FOUND;
            end
          endcase
        end
      end

      // turn the ring back until the list start sits in cell zero
      S_REWIND: begin
        if (pos != '0) begin
          ctrl.rot_prev = 1'b1;
          pos_next      = pos - IDX_W'(1);
        end else begin
          state_next = S_SCAN;
        end
      end

      // compare cell zero, step forward one entry a cycle
      S_SCAN: begin
        if (head == query) begin
          st_next    = ST_OK;
          state_next = S_RESULT;
        end else if (pos_plus < count) begin
          ctrl.rot_next = 1'b1;
          pos_next      = pos + IDX_W'(1);
        end else begin
          st_next    = ST_NOT_FOUND;
          state_next = S_RESTORE;
        end
      end

      // no match: return the old cursor entry to cell zero
      S_RESTORE: begin
        if (pos != saved) begin
          ctrl.rot_prev = 1'b1;
          pos_next      = pos - IDX_W'(1);
        end else begin
          state_next = S_RESULT;
        end
      end

      // load the output register once it is free
      S_RESULT: begin
        if (!res_valid || res_ready) begin
          res_valid_next    = 1'b1;
          res_id_valid_next = (count != '0);
          res_id_next       = (count != '0) ? head : '0;
          res_status_next   = st;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/playlist_cursor_list_core.sv =====
// playlist cursor list: ordered list of up to DEPTH identifiers with a cursor
//
// cmd channel (valid/ready) carries opcode and song_id: append, next,
// previous, switch. res channel returns one beat per command: the id under
// the cursor, a flag that the list is nonempty, and a status code.
//
// the list lives in a ring of DEPTH cells that turns so the cursor entry is
// always in cell zero; next and previous turn the ring one step.
// append, next and previous go from accept through the result state to the
// output register. switch rewinds to the list start, scans one entry a
// cycle and on a miss turns back to the old cursor before its result. one
// command is in work at a time; a new command is accepted while the
// previous result waits in the output register, and its result is held
// until that register is taken.
// reset (rst, synchronous) empties the list and drops any pending result;
// cell contents are not cleared, only entries below the count are read.
// a stalled receiver holds the result beat steady.
module playlist_cursor_list_core
  import plmc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  plmc_cmd_if.sink  cmd,
  plmc_res_if.source res
);

  ring_ctrl_t      ctrl;
  logic [ID_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0] we;
  logic            res_valid;
  logic [ID_W-1:0] res_id;
  logic            res_id_valid;
  status_t         res_status;
  logic            cmd_ready;

  plmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd_ready),
    .cmd_opcode   (cmd.opcode),
    .cmd_song_id  (cmd.song_id),
    .head         (entry[0]),
    .ctrl         (ctrl),
    .res_valid    (res_valid),
    .res_ready    (res.ready),
    .res_id       (res_id),
    .res_id_valid (res_id_valid),
    .res_status   (res_status)
  );

  // ring of cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign we[i] = ctrl.wr_en && (ctrl.wr_off == IDX_W'(i));

    plmc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .we         (we[i]),
      .from_left  (entry[(i + DEPTH - 1) % DEPTH]),
      .from_right (entry[(i + 1) % DEPTH]),
      .entry      (entry[i])
    );
  end

  // channel outputs
  assign cmd.ready         = cmd_ready;
  assign res.valid         = res_valid;
  assign res.current_id    = res_id;
  assign res.current_valid = res_id_valid;
  assign res.status        = res_status;

endmodule

// ===== design/plmc_checker.sv =====
module plmc_checker
  import plmc_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_ready,
  input logic [ID_W-1:0] current_id,
  input logic            current_valid,
  input logic [2:0]      status
);

  // an empty list reports id zero
  a_empty_id_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !current_valid |-> current_id == '0)
    else $error("empty list result carries nonzero id");

  // success always leaves a nonempty list
  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_OK |-> current_valid)
    else $error("ok status with empty list");

  // a full list is never empty
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_FULL |-> current_valid)
    else $error("full status with empty list");

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(current_id) && $stable(status))
    else $error("result beat changed while stalled");

endmodule

bind playlist_cursor_list_core plmc_checker u_plmc_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .current_id    (res.current_id),
  .current_valid (res.current_valid),
  .status        (res.status)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import plmc_pkg::*;

  localparam int RUN_LIMIT    = 3_000_000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 3 * DEPTH + 32;

  typedef struct {
    opcode_t         op;
    logic [ID_W-1:0] id;
  } command_t;

  typedef struct {
    logic [ID_W-1:0] current_id;
    logic            current_valid;
    status_t         status;
  } cursor_report_t;

  logic clk;
  logic rst;

  plmc_cmd_if cmd_bus ();
  plmc_res_if res_bus ();

  playlist_cursor_list_core DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  // commands waiting to be sent and cursor reports waiting to come back
  command_t       commands_to_send[$];
  cursor_report_t reports_due[$];

  // predicted list contents, length and cursor
  logic [ID_W-1:0] model_ids[DEPTH];
  int              model_len;
  int              model_cursor;

  // identifiers appended so far, used to aim switch commands at real entries
  logic [ID_W-1:0] sent_ids[DEPTH];
  int              sent_len;

  int  error_count;
  int  cycle_count;
  int  cmd_gap;
  int  res_stall;
  bit  cmd_burst;
  bit  res_burst;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one accepted command to the predicted list and queue its report
  task automatic apply_command(input opcode_t op, input logic [ID_W-1:0] id);
    cursor_report_t rpt;
    status_t        st;
    st = ST_OK;
    case (op)
      OP_APPEND: begin
        if (model_len >= DEPTH) begin
          st = ST_FULL;
        end else begin
          model_ids[model_len] = id;
          if (model_len == 0) model_cursor = 0;
          model_len++;
        end
      end
      OP_NEXT: begin
        if (model_len != 0 && model_cursor + 1 < model_len) model_cursor++;
        else st = ST_NO_NEXT;
      end
      OP_PREV: begin
        if (model_len != 0 && model_cursor > 0) model_cursor--;
        else st = ST_NO_PREV;
      end
      default: begin
        st = ST_NOT_FOUND;
        for (int i = 0; i < model_len; i++) begin
          if (model_ids[i] == id) begin
            model_cursor = i;
            st = ST_OK;
            break;
          end
        end
      end
    endcase
    if (model_len != 0) begin
      rpt.current_id    = model_ids[model_cursor];
      rpt.current_valid = 1'b1;
    end else begin
      rpt.current_id    = '0;
      rpt.current_valid = 1'b0;
    end
    rpt.status = st;
    reports_due.push_back(rpt);
  endtask

  // queue a command and remember appended identifiers for later switches
  task automatic queue_command(input opcode_t op, input logic [ID_W-1:0] id);
    command_t c;
    c.op = op;
    c.id = id;
    commands_to_send.push_back(c);
    if (op == OP_APPEND && sent_len < DEPTH) begin
      sent_ids[sent_len] = id;
      sent_len++;
    end
  endtask

  function automatic logic [ID_W-1:0] random_id();
    logic [ID_W-1:0] v;
    case ($urandom_range(0, 7))
      4, 5:    v = ID_W'($urandom_range(0, 15));
      6:       v = '1;
      7:       v = (sent_len != 0) ? sent_ids[$urandom_range(0, sent_len - 1)] : '0;
      default: v = ID_W'($urandom);
    endcase
    return v;
  endfunction

  // command driver
  always @(posedge clk) begin
    command_t c;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        apply_command(cmd_bus.opcode, cmd_bus.song_id);
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_gap != 0) begin
          cmd_gap--;
          cmd_bus.valid <= 1'b0;
        end else if (commands_to_send.size() != 0) begin
          c = commands_to_send.pop_front();
          cmd_bus.valid   <= 1'b1;
          cmd_bus.opcode  <= c.op;
          cmd_bus.song_id <= c.id;
          if ($urandom_range(0, 49) == 0) cmd_burst = !cmd_burst;
          cmd_gap = cmd_burst ? 0 : $urandom_range(0, 15);
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    cursor_report_t exp_rpt;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected beat id=%h valid=%b status=%0d", $time,
                   res_bus.current_id, res_bus.current_valid, res_bus.status);
          error_count++;
        end else begin
          exp_rpt = reports_due.pop_front();
          if (res_bus.current_id !== exp_rpt.current_id ||
              res_bus.current_valid !== exp_rpt.current_valid ||
              res_bus.status !== exp_rpt.status) begin
            $display("%0t: mismatch expected id=%h valid=%b status=%0d, actual id=%h valid=%b status=%0d",
                     $time, exp_rpt.current_id, exp_rpt.current_valid, exp_rpt.status,
                     res_bus.current_id, res_bus.current_valid, res_bus.status);
            error_count++;
          end
        end
        if ($urandom_range(0, 49) == 0) res_burst = !res_burst;
        res_stall = res_burst ? 0 : $urandom_range(0, 15);
      end
      if (res_stall != 0) begin
        res_stall--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int      pick;
    opcode_t op;
    clk             = 1'b0;
    rst             = 1'b1;
    cmd_bus.valid   = 1'b0;
    cmd_bus.opcode  = OP_APPEND;
    cmd_bus.song_id = '0;
    res_bus.ready   = 1'b0;
    model_len       = 0;
    model_cursor    = 0;
    sent_len        = 0;
    error_count     = 0;
    cycle_count     = 0;
    cmd_gap         = 0;
    res_stall       = 0;
    cmd_burst       = 1'b0;
    res_burst       = 1'b0;

    // moves and search on an empty list
    queue_command(OP_NEXT, '1);
    queue_command(OP_PREV, '0);
    queue_command(OP_SWITCH, '0);
    // single entry: both ends at once
    queue_command(OP_APPEND, '1);
    queue_command(OP_NEXT, '0);
    queue_command(OP_PREV, '1);
    // a few more entries, with a duplicate of zero
    queue_command(OP_APPEND, '0);
    queue_command(OP_APPEND, 31'h2AAA_AAAA);
    queue_command(OP_APPEND, 31'h5555_5555);
    queue_command(OP_APPEND, '0);
    queue_command(OP_NEXT, 31'h1234_5678);
    queue_command(OP_NEXT, 31'h5555_5555);
    queue_command(OP_NEXT, 31'h2AAA_AAAA);
    // duplicate resolves to the earliest entry
    queue_command(OP_SWITCH, '0);
    queue_command(OP_SWITCH, 31'h1234_5678);
    queue_command(OP_SWITCH, '1);
    queue_command(OP_PREV, '0);
    queue_command(OP_SWITCH, 31'h5555_5555);
    queue_command(OP_NEXT, '0);
    queue_command(OP_NEXT, '1);
    queue_command(OP_PREV, '1);

    // random mix; appends keep coming so the list fills up and rejects
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        queue_command(OP_APPEND, random_id());
      end else if (pick < 55) begin
        queue_command(OP_NEXT, ID_W'($urandom));
      end else if (pick < 75) begin
        queue_command(OP_PREV, ID_W'($urandom));
      end else if (sent_len != 0 && $urandom_range(0, 9) < 7) begin
        queue_command(OP_SWITCH, sent_ids[$urandom_range(0, sent_len - 1)]);
      end else begin
        op = OP_SWITCH;
        queue_command(op, random_id());
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // wait for every command to go out and every report to come back
    while (commands_to_send.size() != 0 || cmd_bus.valid || reports_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (reports_due.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, reports_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
